// File: rtl/sha256_pkg.sv
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_RUN,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_SPILL,
        PH_FINAL
    } t_phase;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        run_end;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_beat;

    function automatic logic [31:0] f_init(input logic [2:0] i);
        logic [31:0] v;
        unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[t];
    endfunction

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/sha256_if.sv
interface sha256_in_if;
    logic                      valid;
    logic                      ready;
    sha256_pkg::t_in_beat      data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sha256_out_if;
    logic                      valid;
    logic                      ready;
    sha256_pkg::t_out_beat     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sha256_round.sv
module sha256_round (
    input  logic [255:0] i_vars,
    input  logic [31:0]  i_w,
    input  logic [31:0]  i_k,
    output logic [255:0] o_vars
);
    import sha256_pkg::*;

    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s1, ch, t1, s0, mj;

    always_comb begin
        {a, b, c, d, e, f, g, h} = i_vars;
        s1 = f_rotr(e, 6) ^ f_rotr(e, 11) ^ f_rotr(e, 25);
        ch = (e & f) ^ (~e & g);
        t1 = h + s1 + ch + i_k + i_w;
        s0 = f_rotr(a, 2) ^ f_rotr(a, 13) ^ f_rotr(a, 22);
        mj = (a & b) ^ (a & c) ^ (b & c);
        o_vars = {t1 + s0 + mj, a, b, c, d + t1, e, f, g};
    end
endmodule

// File: rtl/sha256_hash_engine_unit.sv
// SHA-256 engine taking one message byte per beat, a last flag ending the message.
// while idle a byte beat is taken every cycle and written into a 16-word schedule
// memory; a full block then runs 64 rounds, each made of two memory reads, two more
// reads, a schedule word update and the state update, plus a fold of the result into
// the chaining value, during which input is held off. The last beat starts a padding
// pass over the 16 words (a read and a write per word) and one more block; when fewer
// than 9 bytes of the block are free, a second padding pass and block follow. The
// digest then leaves as eight beats, word 0 first, stretched by any output stalls,
// and the engine reinitializes for the next message.
module sha256_hash_engine_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha256_in_if.sink    s_in,
    sha256_out_if.source m_out
);
    import sha256_pkg::*;

    logic [31:0]  r_w [16];
    logic [31:0]  r_h [8];
    logic [255:0] r_v, n_v;
    logic [63:0]  r_bits;
    logic [5:0]   r_pos;
    logic [5:0]   r_t;
    logic [1:0]   r_sub;
    logic [31:0]  r_x, r_y, r_z, r_cur;
    logic [3:0]   r_padw;
    logic         r_last;
    t_phase       r_ph;
    logic [2:0]   r_oi;
    t_state       r_st, n_st;

    logic [31:0]  s0, s1, wt, pad_word, keep_mask;
    logic [3:0]   ti;
    logic [4:0]   lane;
    logic         fits;
    logic         in_beat;

    assign in_beat = s_in.valid && s_in.ready;

    always_comb begin
        ti = r_t[3:0];
        lane = {~r_pos[1:0], 3'b000};
        s0 = f_rotr(r_x, 7) ^ f_rotr(r_x, 18) ^ (r_x >> 3);
        s1 = f_rotr(r_y, 17) ^ f_rotr(r_y, 19) ^ (r_y >> 10);
        wt = (r_t >= 6'd16) ? r_cur + s0 + r_z + s1 : r_cur;
    end

    sha256_round u_round (.i_vars(r_v), .i_w(r_cur), .i_k(f_k(r_t)), .o_vars(n_v));

    // padding word: 0x80 at the byte after the message, length in the last two
    always_comb begin
        fits = (r_pos <= 6'd55);
        keep_mask = ~(32'hffffffff >> {r_pos[1:0], 3'b000});
        pad_word = '0;
        if (r_ph != PH_SPILL) begin
            if (r_padw == r_pos[5:2]) begin
                pad_word = (r_cur & keep_mask) | (32'h80000000 >> {r_pos[1:0], 3'b000});
            end else if (r_padw < r_pos[5:2]) begin
                pad_word = r_cur;
            end
        end
        if (r_ph == PH_SPILL || fits) begin
            if (r_padw == 4'd14) pad_word = r_bits[63:32];
            if (r_padw == 4'd15) pad_word = r_bits[31:0];
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_LOAD: if (in_beat) begin
                if (s_in.data.has_byte && r_pos == 6'd63) n_st = ST_RUN;
                else if (s_in.data.is_last) n_st = ST_PAD;
            end
            ST_PAD:  if (r_sub == 2'd1 && r_padw == 4'd15) n_st = ST_RUN;
            ST_RUN:  if (r_sub == 2'd3 && r_t == 6'd63) n_st = ST_FOLD;
            ST_FOLD: begin
                if (r_ph == PH_FINAL) n_st = ST_OUT;
                else if (r_last) n_st = ST_PAD;
                else n_st = ST_LOAD;
            end
            ST_OUT:  if (m_out.ready && r_oi == 3'd7) n_st = ST_LOAD;
            default: n_st = ST_LOAD;
        endcase
    end

    always_comb begin
        s_in.ready = (r_st == ST_LOAD);
        m_out.valid = (r_st == ST_OUT);
        m_out.data.digest_word = r_h[r_oi];
        m_out.data.word_number = r_oi;
        m_out.data.run_end = (r_oi == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD;
            r_bits <= '0;
            r_pos <= '0;
            r_t <= '0;
            r_sub <= '0;
            r_padw <= '0;
            r_last <= 1'b0;
            r_ph <= PH_DATA;
            r_oi <= '0;
            r_v <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= f_init(3'(i));
        end else begin
            r_st <= n_st;
            unique case (r_st)
                ST_LOAD: begin
                    if (in_beat) begin
                        if (s_in.data.has_byte) begin
                            r_w[r_pos[5:2]][lane +: 8] <= s_in.data.data_byte;
                            r_bits <= r_bits + 64'd8;
                            r_pos <= r_pos + 6'd1;
                        end
                        r_last <= s_in.data.is_last;
                        r_v <= {r_h[0], r_h[1], r_h[2], r_h[3],
                                r_h[4], r_h[5], r_h[6], r_h[7]};
                        r_t <= '0;
                        r_sub <= '0;
                        r_padw <= '0;
                    end
                end
                ST_PAD: begin
                    if (r_sub == 2'd0) begin
                        r_cur <= r_w[r_padw];
                        r_sub <= 2'd1;
                    end else begin
                        r_w[r_padw] <= pad_word;
                        r_padw <= r_padw + 4'd1;
                        r_sub <= 2'd0;
                        if (r_padw == 4'd15) begin
                            r_v <= {r_h[0], r_h[1], r_h[2], r_h[3],
                                    r_h[4], r_h[5], r_h[6], r_h[7]};
                            r_t <= '0;
                            if (r_ph == PH_SPILL || fits) r_ph <= PH_FINAL;
                            else r_ph <= PH_SPILL;
                        end
                    end
                end
                ST_RUN: begin
                    unique case (r_sub)
                        2'd0: begin
                            r_x <= r_w[4'(ti + 4'd1)];
                            r_y <= r_w[4'(ti + 4'd14)];
                            r_sub <= 2'd1;
                        end
                        2'd1: begin
                            r_z <= r_w[4'(ti + 4'd9)];
                            r_cur <= r_w[ti];
                            r_sub <= 2'd2;
                        end
                        2'd2: begin
                            r_w[ti] <= wt;
                            r_cur <= wt;
                            r_sub <= 2'd3;
                        end
                        2'd3: begin
                            r_v <= n_v;
                            r_t <= r_t + 6'd1;
                            r_sub <= 2'd0;
                        end
                    endcase
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[(7 - i) * 32 +: 32];
                    end
                    r_padw <= '0;
                    r_sub <= '0;
                end
                ST_OUT: begin
                    if (m_out.ready) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= f_init(3'(i));
                            r_bits <= '0;
                            r_pos <= '0;
                            r_padw <= '0;
                            r_last <= 1'b0;
                            r_ph <= PH_DATA;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_hash_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch.sink),
        .m_out   (out_ch.source)
    );

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // digest model state
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    logic [63:0] msg_bits;
    logic [5:0]  fill;

    t_in_beat  pending_beats [$];
    t_out_beat digest_words [$];
    int  n_errors = 0;
    int  phase = 0;
    bit  in_taken = 1'b0;

    function automatic logic [31:0] rr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic run_block();
        logic [31:0] v [8];
        logic [31:0] x, y, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hv[i];
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                x = blk[(t + 1) & 15];
                y = blk[(t + 14) & 15];
                blk[t & 15] = blk[t & 15] + (rr(x, 7) ^ rr(x, 18) ^ (x >> 3))
                    + blk[(t + 9) & 15] + (rr(y, 17) ^ rr(y, 19) ^ (y >> 10));
            end
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + blk[t & 15];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
    endtask

    task automatic put_byte(input logic [5:0] pos, input logic [7:0] b);
        blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
    endtask

    task automatic predict_digest(input t_in_beat b);
        t_out_beat w;
        if (b.has_byte) begin
            put_byte(fill, b.data_byte);
            msg_bits = msg_bits + 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0) run_block();
        end
        if (!b.is_last) return;
        put_byte(fill, 8'h80);
        for (int i = fill + 1; i < 64; i++) put_byte(i[5:0], 8'h00);
        if (fill > 6'd55) begin
            run_block();
            for (int i = 0; i < 16; i++) blk[i] = '0;
        end
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        run_block();
        for (int i = 0; i < 8; i++) begin
            w.digest_word = hv[i];
            w.word_number = i[2:0];
            w.run_end = (i == 7);
            digest_words.push_back(w);
        end
        for (int i = 0; i < 8; i++) hv[i] = IV[i];
        msg_bits = '0;
        fill = '0;
    endtask

    function automatic bit draw(input int pct);
        return int'($urandom_range(99)) < pct;
    endfunction

    function automatic int idle_pct(input bit rx);
        case (phase)
            1: return rx ? 0 : 57;
            2: return rx ? 57 : 0;
            3: return 6;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !draw(idle_pct(1));
            if (!in_ch.valid || in_taken) begin
                if (pending_beats.size() > 0 && !draw(idle_pct(0))) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_beats.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat exp_w;
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) predict_digest(in_ch.data);
            if (out_ch.valid && out_ch.ready) begin
                if (digest_words.size() == 0) begin
                    $error("unexpected digest beat %h", out_ch.data);
                    n_errors++;
                end else begin
                    exp_w = digest_words.pop_front();
                    if (out_ch.data.digest_word !== exp_w.digest_word) begin
                        $error("digest_word exp %h got %h", exp_w.digest_word,
                            out_ch.data.digest_word);
                        n_errors++;
                    end
                    if (out_ch.data.word_number !== exp_w.word_number) begin
                        $error("word_number exp %0d got %0d", exp_w.word_number,
                            out_ch.data.word_number);
                        n_errors++;
                    end
                    if (out_ch.data.run_end !== exp_w.run_end) begin
                        $error("run_end exp %0d got %0d", exp_w.run_end,
                            out_ch.data.run_end);
                        n_errors++;
                    end
                end
            end
        end
    end

    function automatic t_in_beat mk(input logic [7:0] d, input bit hb, input bit last);
        t_in_beat b;
        b.data_byte = d;
        b.has_byte = hb;
        b.is_last = last;
        return b;
    endfunction

    task automatic queue_message(input int len, input bit last_has_byte);
        for (int i = 0; i < len; i++)
            pending_beats.push_back(mk(8'($urandom_range(255)), 1'b1,
                last_has_byte && i == len - 1));
        if (!last_has_byte || len == 0)
            pending_beats.push_back(mk(8'($urandom_range(255)), 1'b0, 1'b1));
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (digest_words.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int len;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 8; i++) hv[i] = IV[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        msg_bits = '0;
        fill = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // empty message, then short with field extremes
        queue_message(0, 1'b0);
        pending_beats.push_back(mk(8'h00, 1'b1, 1'b0));
        pending_beats.push_back(mk(8'hff, 1'b1, 1'b0));
        pending_beats.push_back(mk(8'h80, 1'b0, 1'b0));
        pending_beats.push_back(mk(8'h7f, 1'b1, 1'b1));
        queue_message(3, 1'b0);
        queue_message(1, 1'b1);
        drain();
        // padding spilling into a second block, then short random messages
        for (phase = 0; phase < 4; phase++) begin
            if (phase == 0) begin
                queue_message(56, 1'b0);
            end else begin
                for (int m = 0; m < 2; m++) begin
                    len = $urandom_range(12);
                    queue_message(len, draw(50));
                    if (draw(20))
                        pending_beats.push_back(mk(8'($urandom_range(255)), 1'b0, 1'b0));
                end
            end
            drain();
        end
        if (n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #3000000;
        $display("testbench: errors");
        $finish;
    end
endmodule
